// ===== rtl/core/hctbp_pkg.sv =====
// Shared types and constants for the Huffman code table bit packer.
// Depends on nothing; used by the controller, the datapath and the top level.
package hctbp_pkg;

   // Field and storage widths.
   localparam int SYMBOL_W     = 7;
   localparam int CODE_W       = 24;
   localparam int LEN_W        = 5;
   localparam int BYTE_W       = 8;
   localparam int ACC_W        = 31;
   localparam int CNT_W        = 5;
   localparam int OP_W         = 2;
   localparam int TABLE_DEPTH  = 128;
   localparam int MAX_CODE_LEN = 24;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   // One code table entry: code length over the right-aligned code word.
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] word;
   } table_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_table;
      logic rd_table;
      logic append;
      logic emit;
      logic flush;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic byte_ready;
      logic pending;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/huffman_code_table_bit_packer.sv =====
// Huffman encoder back end: a 128-entry code table feeding an MSB-first byte
// packer. A load request (op 0) writes one table entry, clamping the length
// to 24 bits. An encode request (op 1) reads the table, appends the code in
// the next cycle, then releases each complete byte (zero to three bytes), one
// per cycle as the result register drains, and returns to idle once no
// complete byte is left; the final byte of a request carries rsp_last. A flush
// request (op 2) sends the held bits as one zero-padded byte once the result
// register is free, and sends no byte if no bits are held. Results are held
// in an output register, so a stalled consumer delays byte release and holds
// off new requests. No clearing pass is run after reset.
// Depends on hctbp_pkg, hctbp_ctrl and hctbp_dp.
module huffman_code_table_bit_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [hctbp_pkg::OP_W-1:0]           req_op,
   input  logic [hctbp_pkg::SYMBOL_W-1:0]       req_symbol,
   input  logic [hctbp_pkg::CODE_W-1:0]         req_code_word,
   input  logic [hctbp_pkg::LEN_W-1:0]          req_code_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hctbp_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                 rsp_last
);

   hctbp_pkg::cmd_type    cmd;
   hctbp_pkg::status_type status;

   // Sequencer for each request.
   hctbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Table, accumulator and result register.
   hctbp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .status          (status)
   );

endmodule

// ===== rtl/core/hctbp_ctrl.sv =====
// Controller state machine for the Huffman code table bit packer.
// Depends on hctbp_pkg; drives the datapath through cmd_type and reads status_type.
module hctbp_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [hctbp_pkg::OP_W-1:0]        req_op,
   input  hctbp_pkg::status_type             status,
   output logic                              req_ready,
   output hctbp_pkg::cmd_type                cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_APPEND = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;
   localparam logic [1:0] S_FLUSH  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      cmd.wr_table = 1'b0;
      cmd.rd_table = 1'b0;
      cmd.append   = 1'b0;
      cmd.emit     = 1'b0;
      cmd.flush    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  hctbp_pkg::OP_LOAD: begin
                     cmd.wr_table = 1'b1;
                  end
                  hctbp_pkg::OP_ENCODE: begin
                     cmd.rd_table = 1'b1;
                     state_in     = S_APPEND;
                  end
                  hctbp_pkg::OP_FLUSH: begin
                     if (status.pending) begin
                        state_in = S_FLUSH;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            // Release one complete byte per cycle while the output register frees up.
            if (!status.byte_ready) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/hctbp_dp.sv =====
// Datapath for the Huffman code table bit packer: code table memory,
// bit accumulator and output byte register. Depends on hctbp_pkg.
module hctbp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hctbp_pkg::cmd_type                   cmd,
   input  logic [hctbp_pkg::SYMBOL_W-1:0]       req_symbol,
   input  logic [hctbp_pkg::CODE_W-1:0]         req_code_word,
   input  logic [hctbp_pkg::LEN_W-1:0]          req_code_length,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [hctbp_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                 rsp_last,
   output hctbp_pkg::status_type                status
);

   localparam int ACC_W  = hctbp_pkg::ACC_W;
   localparam int CNT_W  = hctbp_pkg::CNT_W;
   localparam int CODE_W = hctbp_pkg::CODE_W;
   localparam int LEN_W  = hctbp_pkg::LEN_W;
   localparam int BYTE_W = hctbp_pkg::BYTE_W;

   hctbp_pkg::table_entry_type code_table [hctbp_pkg::TABLE_DEPTH];
   hctbp_pkg::table_entry_type rd_data_ff;
   hctbp_pkg::table_entry_type wr_entry;

   logic [LEN_W-1:0]  len_clamped;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  cnt_after_emit;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [BYTE_W-1:0] rsp_byte_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;

   // Clamp the loaded length and drop code bits above it.
   always_comb begin
      if (req_code_length > LEN_W'(hctbp_pkg::MAX_CODE_LEN)) begin
         len_clamped = LEN_W'(hctbp_pkg::MAX_CODE_LEN);
      end else begin
         len_clamped = req_code_length;
      end
      wr_entry.len  = len_clamped;
      wr_entry.word = req_code_word & ~({CODE_W{1'b1}} << len_clamped);
   end

   // Code table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_table) begin
         code_table[req_symbol] <= wr_entry;
      end
      if (cmd.rd_table) begin
         rd_data_ff <= code_table[req_symbol];
      end
   end

   assign cnt_after_emit = cnt_ff - CNT_W'(BYTE_W);

   // Accumulator update and output byte selection.
   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.append) begin
         acc_in = (acc_ff << rd_data_ff.len) | ACC_W'(rd_data_ff.word);
         cnt_in = cnt_ff + rd_data_ff.len;
      end else if (cmd.emit) begin
         rsp_byte_in  = BYTE_W'(acc_ff >> cnt_after_emit);
         rsp_last_in  = (cnt_after_emit < CNT_W'(BYTE_W));
         rsp_valid_in = 1'b1;
         acc_in       = acc_ff & ~({ACC_W{1'b1}} << cnt_after_emit);
         cnt_in       = cnt_after_emit;
      end else if (cmd.flush) begin
         // Pad the remaining bits with zeros in the low end of the byte.
         rsp_byte_in  = acc_ff[BYTE_W-1:0] << (4'd8 - cnt_ff[3:0]);
         rsp_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
         acc_in       = '0;
         cnt_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last          = rsp_last_ff;
   assign status.byte_ready = (cnt_ff >= CNT_W'(BYTE_W));
   assign status.pending    = (cnt_ff != '0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule
